FILE: sv/csul_pkg.sv
// Package for the cluster power-state judge.
// Holds state codes, root-cluster codes, register indexes, field widths and shared types.
// Used by csul_cfg, csul_judge and cluster_state_by_user_limit.
`timescale 1ns / 1ps

package csul_pkg;

    localparam int STATE_W   = 3;
    localparam int CORE_W    = 5;
    localparam int CORES_W   = 4;
    localparam int FREQ_W    = 22;
    localparam int ROOT_W    = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Core limit value that marks a maximum as unset (-1).
    localparam logic [CORE_W-1:0] CORE_UNSET = '1;

    typedef enum logic [STATE_W-1:0] {
        ST_LL_ONLY = 3'd0,
        ST_L_ONLY  = 3'd1,
        ST_4LL_L   = 3'd2,
        ST_4L_LL   = 3'd3,
        ST_NONE    = 3'd4
    } state_t;

    localparam logic [ROOT_W-1:0] ROOT_NONE = 2'd0;
    localparam logic [ROOT_W-1:0] ROOT_LL   = 2'd1;
    localparam logic [ROOT_W-1:0] ROOT_L    = 2'd2;
    localparam logic [ROOT_W-1:0] ROOT_BIG  = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ANCHOR      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LL_CORES    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_L_CORES     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LL_DEF_FMIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_L_DEF_FMAX  = 3'd4;

    localparam logic [ROOT_W-1:0]  ROOT_RESET     = ROOT_NONE;
    localparam logic [CORES_W-1:0] CORES_RESET    = 4'd4;
    localparam logic [FREQ_W-1:0]  FREQ_DEF_RESET = '0;

    typedef struct packed {
        logic [ROOT_W-1:0]  anchor_cluster;
        logic [CORES_W-1:0] ll_cluster_cores;
        logic [CORES_W-1:0] l_cluster_cores;
        logic [FREQ_W-1:0]  ll_default_min_freq;
        logic [FREQ_W-1:0]  l_default_max_freq;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] current_state;
        logic [CORE_W-1:0]  ll_min_cores;
        logic [CORE_W-1:0]  ll_max_cores;
        logic [CORE_W-1:0]  l_min_cores;
        logic [CORE_W-1:0]  l_max_cores;
        logic [CORE_W-1:0]  big_core_min;
        logic [CORE_W-1:0]  big_core_max;
        logic [FREQ_W-1:0]  ll_floor_khz;
        logic               ll_freq_unset;
        logic [FREQ_W-1:0]  l_ceil_khz;
        logic               l_freq_unset;
    } item_t;

endpackage

FILE: sv/csul_cfg.sv
// Configuration registers of the cluster power-state judge, behind an APB-style port.
// Depends on csul_pkg for register indexes, widths and the cfg_t bundle.
`timescale 1ns / 1ps

module csul_cfg
    import csul_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [ROOT_W-1:0]    root_reg;
    logic [CORES_W-1:0]   ll_cores_reg;
    logic [CORES_W-1:0]   l_cores_reg;
    logic [FREQ_W-1:0]    ll_def_fmin_reg;
    logic [FREQ_W-1:0]    l_def_fmax_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg        <= ROOT_RESET;
            ll_cores_reg    <= CORES_RESET;
            l_cores_reg     <= CORES_RESET;
            ll_def_fmin_reg <= FREQ_DEF_RESET;
            l_def_fmax_reg  <= FREQ_DEF_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ANCHOR:       root_reg        <= pwdata[ROOT_W-1:0];
                REG_LL_CORES:     ll_cores_reg    <= pwdata[CORES_W-1:0];
                REG_L_CORES:      l_cores_reg     <= pwdata[CORES_W-1:0];
                REG_LL_DEF_FMIN:  ll_def_fmin_reg <= pwdata[FREQ_W-1:0];
                REG_L_DEF_FMAX:   l_def_fmax_reg  <= pwdata[FREQ_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_ANCHOR:       prdata = {{(PDATA_W-ROOT_W){1'b0}}, root_reg};
            REG_LL_CORES:     prdata = {{(PDATA_W-CORES_W){1'b0}}, ll_cores_reg};
            REG_L_CORES:      prdata = {{(PDATA_W-CORES_W){1'b0}}, l_cores_reg};
            REG_LL_DEF_FMIN:  prdata = {{(PDATA_W-FREQ_W){1'b0}}, ll_def_fmin_reg};
            REG_L_DEF_FMAX:   prdata = {{(PDATA_W-FREQ_W){1'b0}}, l_def_fmax_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.anchor_cluster      = root_reg;
    assign cfg.ll_cluster_cores    = ll_cores_reg;
    assign cfg.l_cluster_cores     = l_cores_reg;
    assign cfg.ll_default_min_freq = ll_def_fmin_reg;
    assign cfg.l_default_max_freq  = l_def_fmax_reg;

endmodule

FILE: sv/csul_judge.sv
// Decision logic of the cluster power-state judge: rule tree and root-cluster remap.
// Purely combinational; depends on csul_pkg for state codes, cfg_t and item_t.
`timescale 1ns / 1ps

module csul_judge
    import csul_pkg::*;
(
    input  item_t  item,
    input  cfg_t   cfg,
    output state_t target_state
);

    // One extra bit keeps the sum and the zero-extended core counts in range.
    logic signed [CORE_W:0] ll_min;
    logic signed [CORE_W:0] l_min;
    logic signed [CORE_W:0] b_min;
    logic signed [CORE_W:0] b_max;
    logic signed [CORE_W:0] ll_max;
    logic signed [CORE_W:0] l_max;
    logic signed [CORE_W:0] min_sum;
    logic [FREQ_W-1:0]      ll_fmin;
    logic [FREQ_W-1:0]      l_fmax;
    logic                   freq_ok;
    logic                   ll_off;
    logic                   l_off;
    logic                   l_wanted_alone;
    state_t                 rule_state;

    assign ll_min = $signed({item.ll_min_cores[CORE_W-1], item.ll_min_cores});
    assign l_min  = $signed({item.l_min_cores[CORE_W-1], item.l_min_cores});
    assign b_min  = $signed({item.big_core_min[CORE_W-1], item.big_core_min});
    assign b_max  = $signed({item.big_core_max[CORE_W-1], item.big_core_max});

    // Fall back to the cluster size when a maximum is unset.
    assign ll_max = (item.ll_max_cores == CORE_UNSET)
                  ? $signed({{(CORE_W+1-CORES_W){1'b0}}, cfg.ll_cluster_cores})
                  : $signed({item.ll_max_cores[CORE_W-1], item.ll_max_cores});
    assign l_max  = (item.l_max_cores == CORE_UNSET)
                  ? $signed({{(CORE_W+1-CORES_W){1'b0}}, cfg.l_cluster_cores})
                  : $signed({item.l_max_cores[CORE_W-1], item.l_max_cores});

    assign min_sum = ll_min + l_min;

    assign ll_fmin = item.ll_freq_unset ? cfg.ll_default_min_freq : item.ll_floor_khz;
    assign l_fmax  = item.l_freq_unset  ? cfg.l_default_max_freq  : item.l_ceil_khz;
    assign freq_ok = (l_fmax >= ll_fmin);

    assign ll_off         = (ll_max == '0);
    assign l_off          = (l_max == '0);
    assign l_wanted_alone = (ll_min <= 0) && (l_min > 0);

    always_comb
    begin
        rule_state = ST_NONE;
        case (item.current_state)
            ST_LL_ONLY:
            begin
                if (b_min <= 0)
                begin
                    if (ll_off)                                    rule_state = ST_L_ONLY;
                    else if ((l_min <= 0) || l_off)                rule_state = ST_LL_ONLY;
                    else if (cfg.anchor_cluster == ROOT_LL)        rule_state = ST_4LL_L;
                    else if (ll_min <= 0)                          rule_state = ST_L_ONLY;
                    else if ((min_sum <= l_max) && freq_ok)        rule_state = ST_L_ONLY;
                    else                                           rule_state = ST_4LL_L;
                end
                else
                begin
                    if (ll_off && l_off)                           rule_state = ST_NONE;
                    else if (ll_off || l_wanted_alone)             rule_state = ST_4L_LL;
                    else                                           rule_state = ST_4LL_L;
                end
            end
            ST_L_ONLY:
            begin
                if (b_min <= 0)
                begin
                    if (l_off)                                     rule_state = ST_LL_ONLY;
                    else if ((ll_min <= 0) || ll_off)              rule_state = ST_L_ONLY;
                    else if ((l_min == -1) && freq_ok)             rule_state = ST_L_ONLY;
                    else if ((min_sum <= l_max) && freq_ok)        rule_state = ST_L_ONLY;
                    else                                           rule_state = ST_4L_LL;
                end
                else
                begin
                    if (ll_off && l_off)                           rule_state = ST_NONE;
                    else if (l_off)                                rule_state = ST_4LL_L;
                    else                                           rule_state = ST_4L_LL;
                end
            end
            ST_4LL_L:
            begin
                if (b_max == '0)
                begin
                    if (l_off)                                     rule_state = ST_LL_ONLY;
                    else if (ll_off)                               rule_state = ST_L_ONLY;
                    else if (l_wanted_alone)                       rule_state = ST_4L_LL;
                    else                                           rule_state = ST_4LL_L;
                end
                else
                begin
                    if (ll_off && l_off)                           rule_state = ST_NONE;
                    else if (ll_off || l_wanted_alone)             rule_state = ST_4L_LL;
                    else                                           rule_state = ST_4LL_L;
                end
            end
            ST_4L_LL:
            begin
                if (b_max == '0)
                begin
                    if (ll_off)                                    rule_state = ST_L_ONLY;
                    else if (l_off)                                rule_state = ST_LL_ONLY;
                    else                                           rule_state = ST_4L_LL;
                end
                else
                begin
                    if (ll_off && l_off)                           rule_state = ST_NONE;
                    else if (l_off)                                rule_state = ST_4LL_L;
                    else                                           rule_state = ST_4L_LL;
                end
            end
            default: rule_state = ST_NONE;
        endcase
    end

    // Remap so that the fixed root cluster always stays powered.
    always_comb
    begin
        target_state = rule_state;
        if (cfg.anchor_cluster == ROOT_LL)
        begin
            if (rule_state == ST_L_ONLY)      target_state = ST_NONE;
            else if (rule_state == ST_4L_LL)  target_state = ST_4LL_L;
        end
        else if (cfg.anchor_cluster == ROOT_L)
        begin
            if (rule_state == ST_LL_ONLY)     target_state = ST_NONE;
            else if (rule_state == ST_4LL_L)  target_state = ST_4L_LL;
        end
    end

endmodule

FILE: sv/cluster_state_by_user_limit.sv
// Cluster power-state judge: input word register, decision logic, result register.
// Depends on csul_pkg, csul_cfg and csul_judge.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one word: the current cluster
//   power state, six signed core limits and two frequency limits with unset
//   flags. Output channel (out_valid / out_ready) returns one target_state word
//   per input word, in order.
//   Path: the accepted word is held in the input register, passes through the
//   rule tree and is captured in the result register, which drives out_valid;
//   a low out_ready can hold it back between the two registers.
//   Throughput: one word per cycle while out_ready stays high.
//   Stall: when out_ready is low the result register holds, the input register
//   fills behind it, and in_ready drops only once both are occupied.
//   Reset: rst_n clears both valid flags and loads the configuration defaults
//   (no root cluster, four cores per cluster, default frequencies 0 kHz).
//   Configuration registers sit on the APB-style port at byte address 4*i; write
//   them only while no word is in flight.
`timescale 1ns / 1ps

module cluster_state_by_user_limit
    import csul_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [STATE_W-1:0] current_state,
    input  logic [CORE_W-1:0]  ll_min_cores,
    input  logic [CORE_W-1:0]  ll_max_cores,
    input  logic [CORE_W-1:0]  l_min_cores,
    input  logic [CORE_W-1:0]  l_max_cores,
    input  logic [CORE_W-1:0]  big_core_min,
    input  logic [CORE_W-1:0]  big_core_max,
    input  logic [FREQ_W-1:0]  ll_floor_khz,
    input  logic               ll_freq_unset,
    input  logic [FREQ_W-1:0]  l_ceil_khz,
    input  logic               l_freq_unset,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [STATE_W-1:0] target_state
);

    cfg_t   cfg;
    item_t  in_item;
    item_t  item_reg;
    logic   item_valid_reg;
    state_t judged_state;
    state_t result_reg;
    logic   result_valid_reg;
    logic   result_load;
    logic   item_load;

    csul_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item.current_state = current_state;
    assign in_item.ll_min_cores  = ll_min_cores;
    assign in_item.ll_max_cores  = ll_max_cores;
    assign in_item.l_min_cores   = l_min_cores;
    assign in_item.l_max_cores   = l_max_cores;
    assign in_item.big_core_min  = big_core_min;
    assign in_item.big_core_max  = big_core_max;
    assign in_item.ll_floor_khz  = ll_floor_khz;
    assign in_item.ll_freq_unset = ll_freq_unset;
    assign in_item.l_ceil_khz    = l_ceil_khz;
    assign in_item.l_freq_unset  = l_freq_unset;

    // Advance a stage when the one after it is empty or being drained.
    assign result_load = !result_valid_reg || out_ready;
    assign in_ready    = !item_valid_reg || result_load;
    assign item_load   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (result_load)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= in_item;
        end
        if (result_load && item_valid_reg)
        begin
            result_reg <= judged_state;
        end
    end

    csul_judge u_judge (
        .item         (item_reg),
        .cfg          (cfg),
        .target_state (judged_state)
    );

    assign out_valid    = result_valid_reg;
    assign target_state = result_reg;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> item_valid_reg)
        else $error("accepted word did not reach the input register");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_load) |=> result_valid_reg)
        else $error("input register word did not move to the result register");

    a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_state <= ST_NONE))
        else $error("result carries an undefined state code");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are held");
`endif

endmodule
